### sv/pgrot_pkg.sv
// Shared constants, types and helpers for the point group rotator.
package pgrot_pkg;

    localparam int POINTS    = 64;
    localparam int ADDR_W    = 6;
    localparam int CNT_W     = 7;
    localparam int COORD_W   = 32;
    localparam int ANG_W     = 16;
    localparam int FRAC_W    = 14;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = DIFF_W + ANG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SHR_W     = SUM_W - FRAC_W;
    localparam int ACC_W     = SHR_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS = 1'b0,
        REG_SIN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic              last;
    } pt_tag_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (v > hi)
        begin
            return hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

### sv/pgrot_mem.sv
// Point store: one write port, one registered read port.
module pgrot_mem (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [pgrot_pkg::ADDR_W-1:0] wr_addr,
    input  pgrot_pkg::point_t       wr_data,
    input  logic                    rd_en,
    input  logic [pgrot_pkg::ADDR_W-1:0] rd_addr,
    output pgrot_pkg::point_t       rd_data
);
    import pgrot_pkg::*;

    point_t mem [POINTS];
    point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/pgrot_rot.sv
// Rotation pipeline: center offset, products, rounding, recenter and saturate.
module pgrot_rot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_vld,
    input  pgrot_pkg::point_t              in_pt,
    input  pgrot_pkg::pt_tag_t             in_tag,
    input  logic signed [pgrot_pkg::COORD_W-1:0] cx,
    input  logic signed [pgrot_pkg::COORD_W-1:0] cz,
    input  logic signed [pgrot_pkg::ANG_W-1:0]   cos_angle,
    input  logic signed [pgrot_pkg::ANG_W-1:0]   sin_angle,
    output logic                           busy,
    output logic                           out_vld,
    output logic signed [pgrot_pkg::COORD_W-1:0] out_x,
    output logic signed [pgrot_pkg::COORD_W-1:0] out_y,
    output logic signed [pgrot_pkg::COORD_W-1:0] out_z,
    output pgrot_pkg::pt_tag_t             out_tag
);
    import pgrot_pkg::*;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dz_reg;
    logic signed [PROD_W-1:0]  mxc_reg, mzs_reg, mxs_reg, mzc_reg;
    logic signed [SHR_W-1:0]   shx_reg, shz_reg;
    logic signed [COORD_W-1:0] y2_reg, y3_reg, y4_reg, y5_reg;
    logic signed [COORD_W-1:0] rx_reg, rz_reg;
    pt_tag_t tag2_reg, tag3_reg, tag4_reg, tag5_reg;

    logic signed [SUM_W-1:0] sx_next, sz_next;
    logic signed [ACC_W-1:0] ax_next, az_next;

    always_comb
    begin
        sx_next = SUM_W'(mxc_reg) - SUM_W'(mzs_reg) + ROUND_HALF;
        sz_next = SUM_W'(mxs_reg) + SUM_W'(mzc_reg) + ROUND_HALF;
        ax_next = ACC_W'(shx_reg) + ACC_W'(cx);
        az_next = ACC_W'(shz_reg) + ACC_W'(cz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= in_vld;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg   <= DIFF_W'(in_pt.x) - DIFF_W'(cx);
            dz_reg   <= DIFF_W'(in_pt.z) - DIFF_W'(cz);
            y2_reg   <= in_pt.y;
            tag2_reg <= in_tag;

            mxc_reg  <= PROD_W'(dx_reg) * PROD_W'(cos_angle);
            mzs_reg  <= PROD_W'(dz_reg) * PROD_W'(sin_angle);
            mxs_reg  <= PROD_W'(dx_reg) * PROD_W'(sin_angle);
            mzc_reg  <= PROD_W'(dz_reg) * PROD_W'(cos_angle);
            y3_reg   <= y2_reg;
            tag3_reg <= tag2_reg;

            shx_reg  <= sx_next[SUM_W-1:FRAC_W];
            shz_reg  <= sz_next[SUM_W-1:FRAC_W];
            y4_reg   <= y3_reg;
            tag4_reg <= tag3_reg;

            rx_reg   <= sat32(ax_next);
            rz_reg   <= sat32(az_next);
            y5_reg   <= y4_reg;
            tag5_reg <= tag4_reg;
        end
    end

    assign busy    = v2_reg | v3_reg | v4_reg | v5_reg;
    assign out_vld = v5_reg;
    assign out_x   = rx_reg;
    assign out_y   = y5_reg;
    assign out_z   = rz_reg;
    assign out_tag = tag5_reg;

endmodule

### sv/point_group_rotate_about_box_center_top.sv
// Point group rotator top level: load control, bounds, config and read-out sequencing.
//
// Points are written into the store at one per cycle while bounds of x and z
// are tracked. The beat with group_end closes the group; the box center is
// then formed in the center state, and the stored points are read back through
// the single read port at one per cycle, while the output is not stalled, into
// a four-stage rotate pipeline. Input is stalled after the group_end beat until
// the last rotated point has been taken. Points beyond 64 in one group are
// dropped.
module point_group_rotate_about_box_center_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pgrot_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [pgrot_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [pgrot_pkg::COORD_W-1:0]  coord_z,
    input  logic                                  group_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [pgrot_pkg::COORD_W-1:0]  rot_x,
    output logic signed [pgrot_pkg::COORD_W-1:0]  rot_y,
    output logic signed [pgrot_pkg::COORD_W-1:0]  rot_z,
    output logic [pgrot_pkg::ADDR_W-1:0]          point_index,
    output logic                                  final_point,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pgrot_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pgrot_pkg::ANG_W-1:0]           cfg_data
);
    import pgrot_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CENTER,
        ST_EMIT,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic signed [COORD_W-1:0] lx_reg, hx_reg, lz_reg, hz_reg;
    logic signed [COORD_W-1:0] cx_reg, cz_reg;
    logic signed [ANG_W-1:0]   cos_reg, sin_reg;
    logic    v1_reg;
    pt_tag_t tag1_reg;

    logic in_acc, store_en, adv, issue, last_issue, rot_busy;
    logic signed [DIFF_W-1:0] sum_x, sum_z;
    point_t wr_pt, rd_pt;
    pt_tag_t out_tag;

    assign in_stall   = (state_reg != ST_LOAD);
    assign in_acc     = in_valid && !in_stall;
    assign store_en   = in_acc && (count_reg < CNT_W'(POINTS));
    assign adv        = !out_valid || !out_stall;
    assign issue      = (state_reg == ST_EMIT) && adv;
    assign last_issue = (CNT_W'(rd_addr_reg) == count_reg - CNT_W'(1));
    assign cfg_ready  = 1'b1;

    assign wr_pt.x = coord_x;
    assign wr_pt.y = coord_y;
    assign wr_pt.z = coord_z;

    assign sum_x = DIFF_W'(lx_reg) + DIFF_W'(hx_reg);
    assign sum_z = DIFF_W'(lz_reg) + DIFF_W'(hz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= ANG_W'(1) <<< FRAC_W;
            sin_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COS: cos_reg <= cfg_data;
                REG_SIN: sin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            rd_addr_reg <= '0;
            v1_reg      <= 1'b0;
            tag1_reg    <= '0;
            lx_reg      <= '0;
            hx_reg      <= '0;
            lz_reg      <= '0;
            hz_reg      <= '0;
            cx_reg      <= '0;
            cz_reg      <= '0;
        end
        else
        begin
            if (store_en)
            begin
                if (count_reg == '0)
                begin
                    lx_reg <= coord_x;
                    hx_reg <= coord_x;
                    lz_reg <= coord_z;
                    hz_reg <= coord_z;
                end
                else
                begin
                    if (coord_x < lx_reg) lx_reg <= coord_x;
                    if (coord_x > hx_reg) hx_reg <= coord_x;
                    if (coord_z < lz_reg) lz_reg <= coord_z;
                    if (coord_z > hz_reg) hz_reg <= coord_z;
                end
                count_reg <= count_reg + CNT_W'(1);
            end

            if (adv)
            begin
                v1_reg        <= issue;
                tag1_reg.idx  <= rd_addr_reg;
                tag1_reg.last <= last_issue;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc && group_end)
                    begin
                        state_reg <= ST_CENTER;
                    end
                end
                ST_CENTER:
                begin
                    cx_reg      <= sum_x[DIFF_W-1:1];
                    cz_reg      <= sum_z[DIFF_W-1:1];
                    rd_addr_reg <= '0;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                        if (last_issue)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !rot_busy)
                    begin
                        count_reg <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    pgrot_mem u_mem (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_pt),
        .rd_en   (issue),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_pt)
    );

    pgrot_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_vld    (v1_reg),
        .in_pt     (rd_pt),
        .in_tag    (tag1_reg),
        .cx        (cx_reg),
        .cz        (cz_reg),
        .cos_angle (cos_reg),
        .sin_angle (sin_reg),
        .busy      (rot_busy),
        .out_vld   (out_valid),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_z     (rot_z),
        .out_tag   (out_tag)
    );

    assign point_index = out_tag.idx;
    assign final_point = out_tag.last;

endmodule
